/* rtl/hangul_jamo_composer_top_assert.svh */
// Assertion macros of the composer RTL, used in hjc_back.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HANGUL_JAMO_COMPOSER_TOP_ASSERT_SVH
`define HANGUL_JAMO_COMPOSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HJC_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define HJC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define HJC_ASSERT(label, pre, post, msg)
`define HJC_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* rtl/hjc_pkg.sv */
// Types, constants and jamo tables of the Hangul jamo composer.
// No dependencies; used by every module of the block.
`default_nettype none
package hjc_pkg;

  localparam logic [4:0]  NONE_IDX       = 5'd31;
  localparam logic [5:0]  KEY_COUNT      = 6'd33;
  localparam logic [5:0]  CONSONANT_KEYS = 6'd19;
  localparam logic [4:0]  MEDIAL_COUNT   = 5'd21;
  localparam logic [4:0]  FINAL_COUNT    = 5'd27;
  localparam logic [15:0] SYL_BASE       = 16'hAC00;
  localparam logic [15:0] MEDIAL_JAMO    = 16'h314F;
  localparam int          QDEPTH         = 2;
  localparam int          QPTR_W         = 1;
  localparam int          QCNT_W         = 2;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic        eot;
    logic        is_key;
    logic [5:0]  key;
    logic [20:0] ch;
  } hjc_item_t;

  function automatic logic [5:0] key_of(input logic [20:0] ch);
    logic [5:0] k;
    case (ch)
      21'h3131, 21'h72: k = 6'd0;
      21'h3132, 21'h52: k = 6'd1;
      21'h3134, 21'h73: k = 6'd2;
      21'h3137, 21'h65: k = 6'd3;
      21'h3138, 21'h45: k = 6'd4;
      21'h3139, 21'h66: k = 6'd5;
      21'h3141, 21'h61: k = 6'd6;
      21'h3142, 21'h71: k = 6'd7;
      21'h3143, 21'h51: k = 6'd8;
      21'h3145, 21'h74: k = 6'd9;
      21'h3146, 21'h54: k = 6'd10;
      21'h3147, 21'h64: k = 6'd11;
      21'h3148, 21'h77: k = 6'd12;
      21'h3149, 21'h57: k = 6'd13;
      21'h314a, 21'h63: k = 6'd14;
      21'h314b, 21'h7A: k = 6'd15;
      21'h314c, 21'h78: k = 6'd16;
      21'h314d, 21'h76: k = 6'd17;
      21'h314e, 21'h67: k = 6'd18;
      21'h314f, 21'h6B: k = 6'd19;
      21'h3150, 21'h6F: k = 6'd20;
      21'h3151, 21'h69: k = 6'd21;
      21'h3152, 21'h4F: k = 6'd22;
      21'h3153, 21'h6A: k = 6'd23;
      21'h3154, 21'h70: k = 6'd24;
      21'h3155, 21'h75: k = 6'd25;
      21'h3156, 21'h50: k = 6'd26;
      21'h3157, 21'h68: k = 6'd27;
      21'h315b, 21'h79: k = 6'd28;
      21'h315c, 21'h6E: k = 6'd29;
      21'h3160, 21'h62: k = 6'd30;
      21'h3161, 21'h6D: k = 6'd31;
      21'h3163, 21'h6C: k = 6'd32;
      default:          k = KEY_COUNT;
    endcase
    return k;
  endfunction

  function automatic logic [20:0] jamo_key(input logic [5:0] key);
    logic [20:0] c;
    case (key)
      6'd0:  c = 21'h3131;  6'd1:  c = 21'h3132;  6'd2:  c = 21'h3134;
      6'd3:  c = 21'h3137;  6'd4:  c = 21'h3138;  6'd5:  c = 21'h3139;
      6'd6:  c = 21'h3141;  6'd7:  c = 21'h3142;  6'd8:  c = 21'h3143;
      6'd9:  c = 21'h3145;  6'd10: c = 21'h3146;  6'd11: c = 21'h3147;
      6'd12: c = 21'h3148;  6'd13: c = 21'h3149;  6'd14: c = 21'h314a;
      6'd15: c = 21'h314b;  6'd16: c = 21'h314c;  6'd17: c = 21'h314d;
      6'd18: c = 21'h314e;  6'd19: c = 21'h314f;  6'd20: c = 21'h3150;
      6'd21: c = 21'h3151;  6'd22: c = 21'h3152;  6'd23: c = 21'h3153;
      6'd24: c = 21'h3154;  6'd25: c = 21'h3155;  6'd26: c = 21'h3156;
      6'd27: c = 21'h3157;  6'd28: c = 21'h315b;  6'd29: c = 21'h315c;
      6'd30: c = 21'h3160;  6'd31: c = 21'h3161;  6'd32: c = 21'h3163;
      default: c = 21'h3131;
    endcase
    return c;
  endfunction

  function automatic logic [20:0] final_code(input logic [4:0] f);
    logic [20:0] c;
    case (f)
      5'd0:  c = 21'h3131;  5'd1:  c = 21'h3132;  5'd2:  c = 21'h3133;
      5'd3:  c = 21'h3134;  5'd4:  c = 21'h3135;  5'd5:  c = 21'h3136;
      5'd6:  c = 21'h3137;  5'd7:  c = 21'h3139;  5'd8:  c = 21'h313a;
      5'd9:  c = 21'h313b;  5'd10: c = 21'h313c;  5'd11: c = 21'h313d;
      5'd12: c = 21'h313e;  5'd13: c = 21'h313f;  5'd14: c = 21'h3140;
      5'd15: c = 21'h3141;  5'd16: c = 21'h3142;  5'd17: c = 21'h3144;
      5'd18: c = 21'h3145;  5'd19: c = 21'h3146;  5'd20: c = 21'h3147;
      5'd21: c = 21'h3148;  5'd22: c = 21'h314a;  5'd23: c = 21'h314b;
      5'd24: c = 21'h314c;  5'd25: c = 21'h314d;  5'd26: c = 21'h314e;
      default: c = 21'h3131;
    endcase
    return c;
  endfunction

  // Consonant key to final index; NONE_IDX when the key cannot be a final.
  function automatic logic [4:0] key_to_final(input logic [4:0] key);
    logic [4:0] f;
    case (key)
      5'd0: f = 5'd0;    5'd1: f = 5'd1;    5'd2: f = 5'd3;    5'd3: f = 5'd6;
      5'd5: f = 5'd7;    5'd6: f = 5'd15;   5'd7: f = 5'd16;   5'd9: f = 5'd18;
      5'd10: f = 5'd19;  5'd11: f = 5'd20;  5'd12: f = 5'd21;  5'd14: f = 5'd22;
      5'd15: f = 5'd23;  5'd16: f = 5'd24;  5'd17: f = 5'd25;  5'd18: f = 5'd26;
      default: f = NONE_IDX;
    endcase
    return f;
  endfunction

  // Single final index to initial index; double finals map to zero.
  function automatic logic [4:0] final_to_initial(input logic [4:0] f);
    logic [4:0] c;
    case (f)
      5'd1: c = 5'd1;    5'd3: c = 5'd2;    5'd6: c = 5'd3;    5'd7: c = 5'd5;
      5'd15: c = 5'd6;   5'd16: c = 5'd7;   5'd18: c = 5'd9;   5'd19: c = 5'd10;
      5'd20: c = 5'd11;  5'd21: c = 5'd12;  5'd22: c = 5'd14;  5'd23: c = 5'd15;
      5'd24: c = 5'd16;  5'd25: c = 5'd17;  5'd26: c = 5'd18;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] key_to_medial(input logic [3:0] v);
    logic [4:0] m;
    case (v)
      4'd9:  m = 5'd12;
      4'd10: m = 5'd13;
      4'd11: m = 5'd17;
      4'd12: m = 5'd18;
      4'd13: m = 5'd20;
      default: m = {1'b0, v};
    endcase
    return m;
  endfunction

  // Double final built from a first consonant (initial index) and a second key.
  function automatic logic [4:0] double_final(input logic [4:0] first, input logic [4:0] key);
    logic [4:0] d;
    d = NONE_IDX;
    if (first == 5'd0 && key == 5'd9) d = 5'd2;
    if (first == 5'd2 && key == 5'd12) d = 5'd4;
    if (first == 5'd2 && key == 5'd18) d = 5'd5;
    if (first == 5'd5) begin
      case (key)
        5'd0:  d = 5'd8;
        5'd6:  d = 5'd9;
        5'd7:  d = 5'd10;
        5'd9:  d = 5'd11;
        5'd16: d = 5'd12;
        5'd17: d = 5'd13;
        5'd18: d = 5'd14;
        default: d = NONE_IDX;
      endcase
    end
    if (first == 5'd7 && key == 5'd9) d = 5'd17;
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/hangul_jamo_composer_top.sv */
// Hangul two-set jamo composer, top level.
//
// Input channel (in_valid/in_ready): one item per code point, in_func = 1 marks
// end of text and flushes the pending syllable. The 33 two-set keys (compatibility
// jamo or Latin letters) are folded into a syllable; other code points flush the
// pending syllable and pass through unchanged.
// Output channel (out_valid/out_ready): one code point per item, out_last_of_run
// set on the last result that an input item causes. An item causes zero, one
// or two results.
// The accepted item is registered in the queue, and its first result in the output
// register; a second result waits in a pending register and follows it.
// Throughput: one item per cycle while the output is ready; an item with two
// results holds the back end while the second result goes out. The two-entry
// queue lets the front keep accepting meanwhile.
// Reset (rst_n low, synchronous) empties the queue and the output and clears
// the pending syllable. When out_ready is low the output register holds its
// result, the back end stops and the queue fills; in_ready drops once it is full.
// Depends on hjc_pkg, hjc_front, hjc_fifo and hjc_back.
`default_nettype none
module hangul_jamo_composer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [20:0] in_char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_code,
  output logic             out_last_of_run
);
  import hjc_pkg::*;

  hjc_item_t q_item;
  hjc_item_t head_item;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      head_valid;

  hjc_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  hjc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  hjc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_item       (head_item),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code        (out_code),
    .out_last_of_run (out_last_of_run)
  );
endmodule
`default_nettype wire

/* rtl/hjc_front.sv */
// Front end: accepts input items and classifies whether each code point is a key.
// Depends on hjc_pkg; feeds hjc_fifo.
`default_nettype none
module hjc_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_func,
  input  wire logic [20:0]       in_char_code,
  input  wire logic              q_full,
  output logic                   q_push,
  output hjc_pkg::hjc_item_t     q_item
);
  import hjc_pkg::*;

  logic [5:0] key;

  assign key      = key_of(in_char_code);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.eot    = in_func;
    q_item.is_key = (key != KEY_COUNT);
    q_item.key    = key;
    q_item.ch     = in_char_code;
  end
endmodule
`default_nettype wire

/* rtl/hjc_fifo.sv */
// Two-entry item queue between the front end and the back end.
// Depends on hjc_pkg for the item type and depth.
`default_nettype none
module hjc_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hjc_pkg::hjc_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output hjc_pkg::hjc_item_t      head_item
);
  import hjc_pkg::*;

  hjc_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule
`default_nettype wire

/* rtl/hjc_back.sv */
// Back end: composition state, result generation and the output register.
// Depends on hjc_pkg and the assertion macro header.
`default_nettype none
`include "hangul_jamo_composer_top_assert.svh"
module hjc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire hjc_pkg::hjc_item_t head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [20:0]            out_code,
  output logic                   out_last_of_run
);
  import hjc_pkg::*;

  typedef struct packed {
    logic [4:0]  ini;
    logic [4:0]  med;
    logic [4:0]  fin;
    logic [1:0]  n;
    logic [20:0] c0;
    logic [20:0] c1;
  } step_t;

  function automatic logic [20:0] syl(input logic [4:0] ini, input logic [4:0] med,
                                      input logic [4:0] fin);
    logic [4:0]  c;
    logic [4:0]  m;
    logic [4:0]  f;
    logic [15:0] s;
    c = (ini < 5'd19) ? ini : 5'd0;
    m = (med < MEDIAL_COUNT) ? med : 5'd0;
    f = (fin < FINAL_COUNT) ? fin + 5'd1 : 5'd0;
    s = SYL_BASE + 16'(c) * 16'd588 + 16'(m) * 16'd28 + 16'(f);
    return {5'd0, s};
  endfunction

  function automatic logic [20:0] lone_ini(input logic [4:0] ini);
    return jamo_key((ini < 5'd19) ? {1'b0, ini} : 6'd0);
  endfunction

  function automatic logic [20:0] lone_med(input logic [4:0] med);
    return {5'd0, MEDIAL_JAMO + 16'((med < MEDIAL_COUNT) ? med : 5'd0)};
  endfunction

  function automatic logic [20:0] lone_fin(input logic [4:0] fin);
    return final_code((fin < FINAL_COUNT) ? fin : 5'd0);
  endfunction

  function automatic step_t step(input logic [4:0] ini_i, input logic [4:0] med_i,
                                 input logic [4:0] fin_i, input hjc_item_t it);
    step_t      s;
    logic [4:0] ck;
    logic [3:0] vk;
    logic [4:0] d;
    logic [4:0] nc;
    logic [4:0] m;
    logic [20:0] fc;
    logic        fv;
    s.ini = ini_i;
    s.med = med_i;
    s.fin = fin_i;
    s.n   = 2'd0;
    s.c0  = '0;
    s.c1  = '0;
    ck    = it.key[4:0];
    vk    = 4'(it.key - CONSONANT_KEYS);
    d     = NONE_IDX;
    nc    = 5'd0;
    m     = med_i;
    fc    = '0;
    fv    = 1'b0;
    if (it.eot || !it.is_key) begin
      // Flush whatever is pending.
      if (ini_i != NONE_IDX) begin
        fv = 1'b1;
        fc = (med_i != NONE_IDX) ? syl(ini_i, med_i, fin_i) : lone_ini(ini_i);
      end else if (med_i != NONE_IDX) begin
        fv = 1'b1;
        fc = lone_med(med_i);
      end else if (fin_i != NONE_IDX) begin
        fv = 1'b1;
        fc = lone_fin(fin_i);
      end
      s.ini = NONE_IDX;
      s.med = NONE_IDX;
      s.fin = NONE_IDX;
      if (it.eot) begin
        s.n  = fv ? 2'd1 : 2'd0;
        s.c0 = fc;
      end else if (fv) begin
        s.n  = 2'd2;
        s.c0 = fc;
        s.c1 = it.ch;
      end else begin
        s.n  = 2'd1;
        s.c0 = it.ch;
      end
    end else if (it.key < CONSONANT_KEYS) begin
      if (med_i != NONE_IDX) begin
        if (ini_i == NONE_IDX) begin
          s.n   = 2'd1;
          s.c0  = lone_med(med_i);
          s.med = NONE_IDX;
          s.ini = ck;
        end else if (fin_i == NONE_IDX) begin
          s.fin = key_to_final(ck);
          if (s.fin == NONE_IDX) begin
            s.n   = 2'd1;
            s.c0  = syl(ini_i, med_i, NONE_IDX);
            s.ini = ck;
            s.med = NONE_IDX;
          end
        end else begin
          if (fin_i < FINAL_COUNT) d = double_final(final_to_initial(fin_i), ck);
          if (fin_i < FINAL_COUNT && (fin_i == 5'd0 || fin_i == 5'd3 || fin_i == 5'd7 ||
              fin_i == 5'd16) && d != NONE_IDX) begin
            s.fin = d;
          end else begin
            s.n   = 2'd1;
            s.c0  = syl(ini_i, med_i, fin_i);
            s.ini = ck;
            s.med = NONE_IDX;
            s.fin = NONE_IDX;
          end
        end
      end else if (ini_i == NONE_IDX) begin
        if (fin_i != NONE_IDX) begin
          s.n   = 2'd1;
          s.c0  = lone_fin(fin_i);
          s.fin = NONE_IDX;
        end
        s.ini = ck;
      end else begin
        d = double_final(ini_i, ck);
        if (d != NONE_IDX) begin
          s.ini = NONE_IDX;
          s.fin = d;
        end else begin
          s.n   = 2'd1;
          s.c0  = lone_ini(ini_i);
          s.ini = ck;
        end
      end
    end else begin
      if (fin_i != NONE_IDX) begin
        // The final (or the second half of a double final) moves to the vowel.
        case (fin_i)
          5'd2:  begin s.fin = 5'd0;  nc = 5'd9;  end
          5'd4:  begin s.fin = 5'd3;  nc = 5'd12; end
          5'd5:  begin s.fin = 5'd3;  nc = 5'd18; end
          5'd8:  begin s.fin = 5'd7;  nc = 5'd0;  end
          5'd9:  begin s.fin = 5'd7;  nc = 5'd6;  end
          5'd10: begin s.fin = 5'd7;  nc = 5'd7;  end
          5'd11: begin s.fin = 5'd7;  nc = 5'd9;  end
          5'd12: begin s.fin = 5'd7;  nc = 5'd16; end
          5'd13: begin s.fin = 5'd7;  nc = 5'd17; end
          5'd14: begin s.fin = 5'd7;  nc = 5'd18; end
          5'd17: begin s.fin = 5'd16; nc = 5'd9;  end
          default: begin
            nc    = (fin_i < FINAL_COUNT) ? final_to_initial(fin_i) : 5'd0;
            s.fin = NONE_IDX;
          end
        endcase
        if (ini_i != NONE_IDX) begin
          s.n  = 2'd1;
          s.c0 = syl(ini_i, med_i, s.fin);
        end else if (s.fin != NONE_IDX) begin
          s.n  = 2'd1;
          s.c0 = lone_fin(s.fin);
        end
        s.ini = nc;
        s.med = NONE_IDX;
        s.fin = NONE_IDX;
        m     = NONE_IDX;
      end
      if (m == NONE_IDX) begin
        s.med = key_to_medial(vk);
      end else if (m == 5'd8 && it.key == 6'd19) begin
        s.med = 5'd9;
      end else if (m == 5'd8 && it.key == 6'd20) begin
        s.med = 5'd10;
      end else if (m == 5'd8 && it.key == 6'd32) begin
        s.med = 5'd11;
      end else if (m == 5'd13 && it.key == 6'd23) begin
        s.med = 5'd14;
      end else if (m == 5'd13 && it.key == 6'd24) begin
        s.med = 5'd15;
      end else if (m == 5'd13 && it.key == 6'd32) begin
        s.med = 5'd16;
      end else if (m == 5'd18 && it.key == 6'd32) begin
        s.med = 5'd19;
      end else begin
        // A vowel that cannot combine goes out on its own right away.
        if (s.ini != NONE_IDX) begin
          s.c0  = syl(s.ini, s.med, s.fin);
          s.ini = NONE_IDX;
        end else begin
          s.c0 = lone_med(s.med);
        end
        s.med = NONE_IDX;
        s.n   = 2'd2;
        s.c1  = jamo_key(it.key);
      end
    end
    return s;
  endfunction

  logic [4:0]  ini_r, ini_nxt;
  logic [4:0]  med_r, med_nxt;
  logic [4:0]  fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [20:0] out_code_r, out_code_nxt;
  logic        out_last_r, out_last_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [20:0] pend_code_r, pend_code_nxt;
  step_t       st;
  logic        can_load;
  logic        load_two;

  assign st       = step(ini_r, med_r, fin_r, head_item);
  assign can_load = !out_valid_r || out_ready;
  assign pop      = head_valid && !pend_valid_r && (can_load || st.n == 2'd0);
  assign load_two = pop && st.n == 2'd2;

  always_comb begin
    ini_nxt        = ini_r;
    med_nxt        = med_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r;
    out_code_nxt   = out_code_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_code_nxt  = pend_code_r;
    if (pop) begin
      ini_nxt = st.ini;
      med_nxt = st.med;
      fin_nxt = st.fin;
    end
    if (pend_valid_r && can_load) begin
      out_valid_nxt  = 1'b1;
      out_code_nxt   = pend_code_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end else if (pop && st.n != 2'd0) begin
      out_valid_nxt  = 1'b1;
      out_code_nxt   = st.c0;
      out_last_nxt   = (st.n == 2'd1);
      pend_valid_nxt = load_two;
      pend_code_nxt  = st.c1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ini_r        <= NONE_IDX;
      med_r        <= NONE_IDX;
      fin_r        <= NONE_IDX;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      ini_r        <= ini_nxt;
      med_r        <= med_nxt;
      fin_r        <= fin_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
    pend_code_r <= pend_code_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code        = out_code_r;
  assign out_last_of_run = out_last_r;

  `HJC_ASSERT(a_pend_behind_first, pend_valid_r, out_valid_r && !out_last_r, "pending result without a first one")
  `HJC_ASSERT(a_no_pop_while_pend, pend_valid_r, !pop, "queue popped while a second result waits")
  `HJC_ASSERT_NEXT(a_two_sets_pend, load_two, pend_valid_r, "second result not held")
  `HJC_ASSERT_NEXT(a_pend_drains, pend_valid_r && out_ready, !pend_valid_r && out_valid_r && out_last_r, "second result not moved to the output")
endmodule
`default_nettype wire

/* tb/hangul_jamo_composer_top_test.sv */
// Self-checking testbench for hangul_jamo_composer_top: a local model of the
// two-set composition rules predicts every output code of a typed item stream.
// Depends only on the RTL of the block; no files or arguments are read.
`default_nettype none
module hangul_jamo_composer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum bit {FN_CHAR = 1'b0, FN_EOT = 1'b1} fn_e;

  typedef struct {
    logic [20:0] code;
    logic        is_last;
  } composed_t;

  localparam logic [4:0]  NO_IDX      = 5'd31;
  localparam int          CONS_KEYS   = 19;
  localparam int          KEYS        = 33;
  localparam int          MED_N       = 21;
  localparam int          FIN_N       = 27;
  localparam int          CHO_STRIDE  = 588;
  localparam int          JUNG_STRIDE = 28;
  localparam logic [20:0] SYL0        = 21'hAC00;
  localparam logic [20:0] MED_JAMO0   = 21'h314F;
  localparam logic [20:0] MAX_CODE    = 21'h1FFFFF;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = 8;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_func      = 1'b0;
  logic [20:0] in_char_code = 21'd0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [20:0] out_code;
  logic        out_last_of_run;

  hangul_jamo_composer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code        (out_code),
    .out_last_of_run (out_last_of_run)
  );

  // Key tables of the two-set layout: consonant keys 0..18, vowel keys 19..32.
  logic [20:0] jamo_tab [KEYS] = '{
    21'h3131, 21'h3132, 21'h3134, 21'h3137, 21'h3138, 21'h3139, 21'h3141, 21'h3142,
    21'h3143, 21'h3145, 21'h3146, 21'h3147, 21'h3148, 21'h3149, 21'h314a, 21'h314b,
    21'h314c, 21'h314d, 21'h314e, 21'h314f, 21'h3150, 21'h3151, 21'h3152, 21'h3153,
    21'h3154, 21'h3155, 21'h3156, 21'h3157, 21'h315b, 21'h315c, 21'h3160, 21'h3161,
    21'h3163};
  logic [20:0] latin_tab [KEYS] = '{
    21'h72, 21'h52, 21'h73, 21'h65, 21'h45, 21'h66, 21'h61, 21'h71, 21'h51, 21'h74,
    21'h54, 21'h64, 21'h77, 21'h57, 21'h63, 21'h7A, 21'h78, 21'h76, 21'h67, 21'h6B,
    21'h6F, 21'h69, 21'h4F, 21'h6A, 21'h70, 21'h75, 21'h50, 21'h68, 21'h79, 21'h6E,
    21'h62, 21'h6D, 21'h6C};
  logic [20:0] fin_jamo [FIN_N] = '{
    21'h3131, 21'h3132, 21'h3133, 21'h3134, 21'h3135, 21'h3136, 21'h3137, 21'h3139,
    21'h313a, 21'h313b, 21'h313c, 21'h313d, 21'h313e, 21'h313f, 21'h3140, 21'h3141,
    21'h3142, 21'h3144, 21'h3145, 21'h3146, 21'h3147, 21'h3148, 21'h314a, 21'h314b,
    21'h314c, 21'h314d, 21'h314e};
  logic [4:0] cons_to_fin [CONS_KEYS] = '{
    5'd0, 5'd1, 5'd3, 5'd6, NO_IDX, 5'd7, 5'd15, 5'd16, NO_IDX, 5'd18,
    5'd19, 5'd20, 5'd21, NO_IDX, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26};
  logic [4:0] fin_to_cho [FIN_N] = '{
    5'd0, 5'd1, 5'd0, 5'd2, 5'd0, 5'd0, 5'd3, 5'd5, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd6, 5'd7, 5'd0, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18};
  logic [4:0] vow_to_jung [14] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd12, 5'd13, 5'd17, 5'd18, 5'd20};

  // Key choices that steer random typing into double medials and double finals.
  int rounded_vowels [3] = '{27, 29, 31};
  int glide_vowels [5] = '{19, 20, 32, 23, 24};
  int pairable_finals [4] = '{0, 2, 5, 7};
  int second_finals [8] = '{9, 12, 18, 0, 6, 7, 16, 17};

  // Pending syllable of the prediction.
  logic [4:0]  s_cho = NO_IDX;
  logic [4:0]  s_jung = NO_IDX;
  logic [4:0]  s_jong = NO_IDX;
  logic [20:0] out_buf [2];
  int          out_n;

  composed_t composed_q [$];
  int        mismatches = 0;
  int        codes_seen = 0;
  int        items_typed = 0;
  int        cycle_count = 0;
  int        send_gap_pct = 0;
  int        sink_stall_pct = 0;
  int        stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes still expected",
               cycle_count, composed_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic void put_code(logic [20:0] c);
    if (out_n < 2) begin
      out_buf[out_n] = c;
      out_n++;
    end
  endfunction

  function automatic logic [20:0] syllable_code();
    int c, m, f;
    c = (s_cho < CONS_KEYS) ? s_cho : 0;
    m = (s_jung < MED_N) ? s_jung : 0;
    f = (s_jong < FIN_N) ? s_jong + 1 : 0;
    return 21'(SYL0 + c * CHO_STRIDE + m * JUNG_STRIDE + f);
  endfunction

  function automatic logic [20:0] lone_cho();
    return jamo_tab[(s_cho < CONS_KEYS) ? s_cho : 0];
  endfunction

  function automatic logic [20:0] lone_jung();
    return 21'(MED_JAMO0 + ((s_jung < MED_N) ? s_jung : 0));
  endfunction

  function automatic logic [20:0] lone_jong();
    return fin_jamo[(s_jong < FIN_N) ? s_jong : 0];
  endfunction

  function automatic int key_of_char(logic [20:0] ch);
    for (int i = 0; i < KEYS; i++)
      if (jamo_tab[i] == ch) return i;
    for (int i = 0; i < KEYS; i++)
      if (latin_tab[i] == ch) return i;
    return KEYS;
  endfunction

  // Double final from a first consonant (as initial index) and a second key.
  function automatic logic [4:0] pair_final(logic [4:0] first, int key);
    if (first == 5'd0 && key == 9) return 5'd2;
    if (first == 5'd2 && key == 12) return 5'd4;
    if (first == 5'd2 && key == 18) return 5'd5;
    if (first == 5'd5) begin
      case (key)
        0:  return 5'd8;
        6:  return 5'd9;
        7:  return 5'd10;
        9:  return 5'd11;
        16: return 5'd12;
        17: return 5'd13;
        18: return 5'd14;
        default: return NO_IDX;
      endcase
    end
    if (first == 5'd7 && key == 9) return 5'd17;
    return NO_IDX;
  endfunction

  function automatic void flush_syllable();
    if (s_cho != NO_IDX) begin
      if (s_jung != NO_IDX) put_code(syllable_code());
      else put_code(lone_cho());
    end else if (s_jung != NO_IDX) begin
      put_code(lone_jung());
    end else if (s_jong != NO_IDX) begin
      put_code(lone_jong());
    end
    s_cho = NO_IDX;
    s_jung = NO_IDX;
    s_jong = NO_IDX;
  endfunction

  function automatic void type_consonant(int key);
    logic [4:0] d;
    if (s_jung != NO_IDX) begin
      if (s_cho == NO_IDX) begin
        put_code(lone_jung());
        s_jung = NO_IDX;
        s_cho = 5'(key);
      end else if (s_jong == NO_IDX) begin
        s_jong = cons_to_fin[key];
        if (s_jong == NO_IDX) begin
          put_code(syllable_code());
          s_cho = 5'(key);
          s_jung = NO_IDX;
        end
      end else begin
        d = (s_jong < FIN_N) ? pair_final(fin_to_cho[s_jong], key) : NO_IDX;
        // Only the single finals g, n, l and b can grow into a double final.
        if ((s_jong == 5'd0 || s_jong == 5'd3 || s_jong == 5'd7 || s_jong == 5'd16) &&
            d != NO_IDX) begin
          s_jong = d;
        end else begin
          put_code(syllable_code());
          s_cho = 5'(key);
          s_jung = NO_IDX;
          s_jong = NO_IDX;
        end
      end
    end else if (s_cho == NO_IDX) begin
      if (s_jong != NO_IDX) begin
        put_code(lone_jong());
        s_jong = NO_IDX;
      end
      s_cho = 5'(key);
    end else begin
      d = pair_final(s_cho, key);
      if (d != NO_IDX) begin
        s_cho = NO_IDX;
        s_jong = d;
      end else begin
        put_code(lone_cho());
        s_cho = 5'(key);
      end
    end
  endfunction

  function automatic void type_vowel(int key);
    logic [4:0] nc;
    logic [4:0] m;
    m = s_jung;
    if (s_jong != NO_IDX) begin
      // The final (or the second half of a double final) moves to the new vowel.
      case (s_jong)
        5'd2:  begin s_jong = 5'd0;  nc = 5'd9;  end
        5'd4:  begin s_jong = 5'd3;  nc = 5'd12; end
        5'd5:  begin s_jong = 5'd3;  nc = 5'd18; end
        5'd8:  begin s_jong = 5'd7;  nc = 5'd0;  end
        5'd9:  begin s_jong = 5'd7;  nc = 5'd6;  end
        5'd10: begin s_jong = 5'd7;  nc = 5'd7;  end
        5'd11: begin s_jong = 5'd7;  nc = 5'd9;  end
        5'd12: begin s_jong = 5'd7;  nc = 5'd16; end
        5'd13: begin s_jong = 5'd7;  nc = 5'd17; end
        5'd14: begin s_jong = 5'd7;  nc = 5'd18; end
        5'd17: begin s_jong = 5'd16; nc = 5'd9;  end
        default: begin
          nc = (s_jong < FIN_N) ? fin_to_cho[s_jong] : 5'd0;
          s_jong = NO_IDX;
        end
      endcase
      if (s_cho != NO_IDX) put_code(syllable_code());
      else if (s_jong != NO_IDX) put_code(lone_jong());
      s_cho = nc;
      s_jung = NO_IDX;
      s_jong = NO_IDX;
      m = NO_IDX;
    end
    if (m == NO_IDX) s_jung = vow_to_jung[key - CONS_KEYS];
    else if (m == 5'd8 && key == 19) s_jung = 5'd9;
    else if (m == 5'd8 && key == 20) s_jung = 5'd10;
    else if (m == 5'd8 && key == 32) s_jung = 5'd11;
    else if (m == 5'd13 && key == 23) s_jung = 5'd14;
    else if (m == 5'd13 && key == 24) s_jung = 5'd15;
    else if (m == 5'd13 && key == 32) s_jung = 5'd16;
    else if (m == 5'd18 && key == 32) s_jung = 5'd19;
    else begin
      // A vowel that cannot join goes out on its own right away.
      if (s_cho != NO_IDX) begin
        put_code(syllable_code());
        s_cho = NO_IDX;
      end else begin
        put_code(lone_jung());
      end
      s_jung = NO_IDX;
      put_code(jamo_tab[key]);
    end
  endfunction

  function automatic void predict_codes(fn_e fn, logic [20:0] ch);
    int key;
    composed_t c;
    out_n = 0;
    if (fn == FN_EOT) begin
      flush_syllable();
    end else begin
      key = key_of_char(ch);
      if (key >= KEYS) begin
        flush_syllable();
        put_code(ch);
      end else if (key < CONS_KEYS) begin
        type_consonant(key);
      end else begin
        type_vowel(key);
      end
    end
    for (int i = 0; i < out_n; i++) begin
      c.code = out_buf[i];
      c.is_last = (i == out_n - 1);
      composed_q.push_back(c);
    end
  endfunction

  // ------------------------------------------------------------------ checking

  function automatic void note_mismatch(string what, composed_t want, logic [20:0] code,
                                        logic last);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected code %h last %b, got code %h last %b",
               what, want.code, want.is_last, code, last);
  endfunction

  always @(posedge clk) begin : check_codes
    composed_t want;
    if (rst_n && out_valid && out_ready) begin
      codes_seen++;
      if (composed_q.size() == 0) begin
        want.code = 21'd0;
        want.is_last = 1'b0;
        note_mismatch("no code expected", want, out_code, out_last_of_run);
      end else begin
        want = composed_q.pop_front();
        if (out_code !== want.code) note_mismatch("code", want, out_code, out_last_of_run);
        else if (out_last_of_run !== want.is_last)
          note_mismatch("last of run", want, out_code, out_last_of_run);
      end
    end
  end

  // Receiver stalls in bursts of random length.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ stimulus

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(fn_e fn, logic [20:0] ch);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_codes(fn, ch);
    items_typed++;
    @(negedge clk);
  endtask

  task automatic send_key(int key);
    send_item(FN_CHAR, $urandom_range(0, 1) ? jamo_tab[key] : latin_tab[key]);
  endtask

  task automatic type_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(FN_CHAR, 21'(s[i]));
  endtask

  task automatic type_syllable();
    send_key($urandom_range(0, CONS_KEYS - 1));
    if ($urandom_range(0, 1)) send_key(rounded_vowels[$urandom_range(0, 2)]);
    else send_key($urandom_range(CONS_KEYS, KEYS - 1));
    if ($urandom_range(0, 2) == 0) send_key(glide_vowels[$urandom_range(0, 4)]);
    if ($urandom_range(0, 1)) begin
      if ($urandom_range(0, 1)) send_key(pairable_finals[$urandom_range(0, 3)]);
      else send_key($urandom_range(0, CONS_KEYS - 1));
      if ($urandom_range(0, 2) == 0) send_key(second_finals[$urandom_range(0, 7)]);
    end
  endtask

  task automatic type_noise();
    case ($urandom_range(0, 5))
      0: send_item(FN_CHAR, 21'($urandom()));
      1: send_item(FN_CHAR, 21'($urandom_range(0, 127)));
      2: send_item(FN_CHAR, 21'($urandom_range(32'h3130, 32'h3190)));
      3: send_item(FN_EOT, 21'($urandom()));
      default: send_key($urandom_range(0, KEYS - 1));
    endcase
  endtask

  task automatic test_pass_through();
    send_item(FN_EOT, MAX_CODE);
    send_item(FN_CHAR, 21'd0);
    send_item(FN_CHAR, MAX_CODE);
    send_item(FN_CHAR, 21'h10FFFF);
  endtask

  task automatic test_double_final_split();
    type_text("rkfrk");
  endtask

  task automatic test_vowel_no_join();
    type_text("hdhkl");
  endtask

  task automatic test_hard_consonant();
    type_text("EkE");
  endtask

  task automatic test_lone_final_split();
    type_text("rtk");
  endtask

  task automatic test_end_of_text();
    send_item(FN_CHAR, jamo_tab[7]);
    send_item(FN_CHAR, jamo_tab[27]);
    send_item(FN_EOT, 21'd0);
    // A compatibility jamo that is not a key passes through.
    send_item(FN_CHAR, 21'h3133);
  endtask

  task automatic test_random_typing(int upto);
    while (items_typed < upto) begin
      if ($urandom_range(0, 99) < 80) type_syllable();
      else type_noise();
    end
  endtask

  task automatic test_random_noise(int upto);
    while (items_typed < upto) type_noise();
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (composed_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_streaming_tail(int upto);
    send_gap_pct = 0;
    sink_stall_pct = 0;
    test_random_typing(upto);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_pass_through();
    test_double_final_split();
    test_vowel_no_join();
    test_hard_consonant();
    test_lone_final_split();
    test_end_of_text();
    send_gap_pct = 15;
    sink_stall_pct = 15;
    test_random_typing(500);
    test_drain_pause();
    send_gap_pct = 30;
    sink_stall_pct = 30;
    test_random_noise(850);
    test_streaming_tail(1150);
    in_valid <= 1'b0;
    while (composed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Typed %0d items: directed composition rules, random syllables, noise,",
             items_typed);
    $display("a full drain and an unthrottled tail; %0d codes checked, %0d mismatches.",
             codes_seen, mismatches);
    if (mismatches == 0 && composed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
